// ----- src/m65enc_pkg.sv -----
`timescale 1ns / 1ps

package m65enc_pkg;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  base_opcode;
		logic [5:0]  arg_flags;
		logic [15:0] operand;
		logic [15:0] location;
		logic        forward_ref;
		logic        force_absolute;
	} instr_t;

	typedef struct packed {
		logic [7:0] opcode_byte;
		logic [7:0] low_byte;
		logic [7:0] high_byte;
		logic [1:0] length;
		logic [2:0] error_code;
	} code_t;

	localparam logic [3:0] K_INHERENT = 4'd0;
	localparam logic [3:0] K_CALL     = 4'd1;
	localparam logic [3:0] K_JUMP     = 4'd2;
	localparam logic [3:0] K_BRANCH   = 4'd3;
	localparam logic [3:0] K_LOGIC    = 4'd4;
	localparam logic [3:0] K_INCDEC   = 4'd5;
	localparam logic [3:0] K_BIT      = 4'd6;
	localparam logic [3:0] K_CPXY     = 4'd7;
	localparam logic [3:0] K_STXY     = 4'd8;
	localparam logic [3:0] K_TWOOP    = 4'd9;
	localparam logic [3:0] K_LDXY     = 4'd10;

	localparam logic [5:0] F_NUM = 6'h01;
	localparam logic [5:0] F_IMM = 6'h02;
	localparam logic [5:0] F_IND = 6'h04;
	localparam logic [5:0] F_X   = 6'h08;
	localparam logic [5:0] F_Y   = 6'h10;
	localparam logic [5:0] F_ACC = 6'h20;

	localparam logic [2:0] E_NONE  = 3'd0;
	localparam logic [2:0] E_ADDR  = 3'd1;
	localparam logic [2:0] E_RANGE = 3'd2;
	localparam logic [2:0] E_VALUE = 3'd3;
	localparam logic [2:0] E_EXTRA = 3'd4;

	localparam logic [7:0] NOP_BYTE  = 8'hEA;
	localparam logic [7:0] OP_STX_ZP = 8'h86;
	localparam logic [7:0] OP_STA_IX = 8'h81;
	localparam logic [7:0] OP_LDX_IM = 8'hA2;

	localparam logic [7:0] OFS_ZP    = 8'h04;
	localparam logic [7:0] OFS_ABS   = 8'h08;
	localparam logic [7:0] OFS_IDX   = 8'h10;
	localparam logic [7:0] OFS_ABSY  = 8'h18;
	localparam logic [7:0] OFS_IND   = 8'h20;

	localparam logic [15:0] BR_MAX   = 16'h007F;
	localparam logic [15:0] BR_MIN   = 16'hFF80;
	localparam logic [15:0] BR_FAIL  = 16'hFFFE;
	localparam logic [15:0] BYTE_MAX = 16'h00FF;

endpackage

// ----- src/mos6502_instruction_encoder.sv -----
// Path: a word accepted into the input register (instr_s1) moves on to the result register (code_s2),
// which drives the code channel, and is held there until the consumer takes it.
// Throughput: one word per cycle while code_ready is high. While a finished result waits for the consumer,
// one more word is taken into the input register, and then instr_ready stays low until the result is taken.
// Reset: arst_n clears both valid flags at once; the payload registers are not reset.
`timescale 1ns / 1ps

module mos6502_instruction_encoder
	import m65enc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   instr_valid,
	output logic   instr_ready,
	input  instr_t instr,
	output logic   code_valid,
	input  logic   code_ready,
	output code_t  code
);

	localparam logic [2:0] T_DONE = 3'd0;
	localparam logic [2:0] T_IMM  = 3'd1;
	localparam logic [2:0] T_INC  = 3'd2;
	localparam logic [2:0] T_IDX  = 3'd3;
	localparam logic [2:0] T_ZP   = 3'd4;

	instr_t instr_s1;
	logic   valid_s1;
	code_t  code_s2;
	logic   valid_s2;
	code_t  enc;
	logic   adv_s2;

	assign adv_s2      = !valid_s2 || code_ready;
	assign instr_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (instr_ready) begin
				valid_s1 <= instr_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (instr_ready && instr_valid) begin
			instr_s1 <= instr;
		end
		if (adv_s2 && valid_s1) begin
			code_s2 <= enc;
		end
	end

	always_comb begin
		logic [7:0]  op;
		logic [15:0] val;
		logic [1:0]  len;
		logic [2:0]  err;
		logic        bad;
		logic [2:0]  tail;
		logic [5:0]  fl;
		logic [5:0]  keep;
		op   = instr_s1.base_opcode;
		val  = instr_s1.operand;
		fl   = instr_s1.arg_flags;
		len  = 2'd3;
		err  = E_NONE;
		bad  = 1'b0;
		tail = T_DONE;
		keep = '0;
		unique case (instr_s1.kind)
			K_INHERENT: begin
				if (fl != 6'd0) err = E_EXTRA;
				len = 2'd1;
			end
			K_CALL: begin
				if (fl != F_NUM) bad = 1'b1;
			end
			K_JUMP: begin
				if (fl == (F_IND | F_NUM)) op = op + OFS_IND;
				else if (fl != F_NUM) bad = 1'b1;
			end
			K_BRANCH: begin
				if (fl != F_NUM) begin
					bad = 1'b1;
				end else begin
					len = 2'd2;
					val = val - instr_s1.location - 16'd2;
					if (val > BR_MAX && val < BR_MIN) begin
						err = E_RANGE;
						val = BR_FAIL;
					end
				end
			end
			K_LOGIC: begin
				if ((fl & F_ACC) != 6'd0) begin
					op  = op + OFS_ZP;
					len = 2'd1;
				end else begin
					tail = T_INC;
				end
			end
			K_INCDEC: begin
				tail = T_INC;
			end
			K_BIT: begin
				if (fl != F_NUM) bad = 1'b1;
				else tail = T_ZP;
			end
			K_CPXY: begin
				if ((fl & F_IMM) != 6'd0) begin
					tail = T_IMM;
				end else begin
					op = op + OFS_ZP;
					if (fl != F_NUM) bad = 1'b1;
					else tail = T_ZP;
				end
			end
			K_STXY: begin
				keep = (op == OP_STX_ZP) ? ~F_Y : ~F_X;
				if ((fl & keep) != F_NUM) begin
					bad = 1'b1;
				end else if ((fl & (F_X | F_Y)) != 6'd0) begin
					if (val > BYTE_MAX) begin
						err = E_VALUE;
						val = 16'd0;
					end
					op  = op + OFS_IDX;
					len = 2'd2;
				end else begin
					tail = T_ZP;
				end
			end
			K_TWOOP: begin
				if ((fl & F_NUM) == 6'd0) begin
					bad = 1'b1;
				end else if ((fl & F_IMM) != 6'd0) begin
					if (op == OP_STA_IX) begin
						bad = 1'b1;
					end else begin
						op   = op + OFS_ABS;
						tail = T_IMM;
					end
				end else if ((fl & F_IND) != 6'd0) begin
					if ((fl & F_Y) != 6'd0) op = op + OFS_IDX;
					else if ((fl & F_X) == 6'd0) bad = 1'b1;
					if (!bad) begin
						if (val > BYTE_MAX) begin
							err = E_VALUE;
							val = 16'd0;
						end
						len = 2'd2;
					end
				end else if ((fl & F_Y) != 6'd0) begin
					op = op + OFS_ABSY;
				end else begin
					op   = op + OFS_ZP;
					tail = T_IDX;
				end
			end
			K_LDXY: begin
				if ((fl & F_IMM) != 6'd0) begin
					tail = T_IMM;
				end else begin
					if (op == OP_LDX_IM && (fl & F_Y) != 6'd0) fl = fl ^ (F_X | F_Y);
					op   = op + OFS_ZP;
					tail = T_INC;
				end
			end
			default: begin
			end
		endcase

		if (!bad && tail == T_IMM) begin
			if (val > BYTE_MAX && val < BR_MIN) begin
				err = E_VALUE;
				val = 16'd0;
			end
			len = 2'd2;
		end
		if (!bad && tail == T_INC) begin
			if ((fl & ~F_X) != F_NUM) bad = 1'b1;
			else tail = T_IDX;
		end
		if (!bad && tail == T_IDX) begin
			if ((fl & F_X) != 6'd0) op = op + OFS_IDX;
			tail = T_ZP;
		end
		if (!bad && tail == T_ZP) begin
			if (!instr_s1.force_absolute && !instr_s1.forward_ref && val <= BYTE_MAX) begin
				len = 2'd2;
			end else begin
				op = op + OFS_ABS;
			end
		end

		if (bad) begin
			enc.opcode_byte = NOP_BYTE;
			enc.low_byte    = NOP_BYTE;
			enc.high_byte   = NOP_BYTE;
			enc.length      = 2'd3;
			enc.error_code  = E_ADDR;
		end else begin
			enc.opcode_byte = op;
			enc.low_byte    = val[7:0];
			enc.high_byte   = val[15:8];
			enc.length      = len;
			enc.error_code  = err;
		end
	end

	assign code_valid = valid_s2;
	assign code       = code_s2;

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> code.length != 2'd0)
		else $error("result word has zero length");

	a_bad_is_nop: assert property (@(posedge clk) disable iff (!arst_n)
		(code_valid && code.error_code == E_ADDR) |->
		(code.opcode_byte == NOP_BYTE && code.low_byte == NOP_BYTE &&
		 code.high_byte == NOP_BYTE && code.length == 2'd3))
		else $error("addressing error without NOP fill");

	a_branch_len: assert property (@(posedge clk) disable iff (!arst_n)
		(code_valid && code.error_code == E_RANGE) |->
		(code.length == 2'd2 && code.low_byte == 8'hFE && code.high_byte == 8'hFF))
		else $error("branch range error with wrong form");

	a_extra_len: assert property (@(posedge clk) disable iff (!arst_n)
		(code_valid && code.error_code == E_EXTRA) |-> code.length == 2'd1)
		else $error("extra operand error on multi-byte word");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !code_ready) |=> (valid_s1 && valid_s2))
		else $error("pipeline word lost during stall");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("input stage word did not reach result register");

endmodule
